// File: design/epoch_seconds_to_calendar_core_macros.svh
// Assertion macros for the epoch seconds to calendar core.
// Used by the checker; expects signals clk and rst in the including scope.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/esc_pkg.sv
// Shared types, constants and functions for the epoch seconds to calendar core.
// No dependencies; every other design file but the assertion macros header imports this package.
package esc_pkg;

  localparam int unsigned EPOCH_W  = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  // Day count, seconds of day and seconds of hour
  localparam int unsigned DAYS_W = 16;
  localparam int unsigned SOD_W  = 17;
  localparam int unsigned SOH_W  = 12;

  localparam logic [SOD_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [SOD_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [SOH_W-1:0] SECS_PER_MIN  = 12'd60;

  // Reciprocals for the constant divisions, after the power-of-two part is shifted out:
  // days = ((t >> 7) * DAY_RECIP) >> 35, hour = ((sod >> 4) * HOUR_RECIP) >> 21,
  // minute = ((soh >> 2) * MIN_RECIP) >> 14, exact over the range each operand can take
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam logic [YEAR_W-1:0]  BASE_YEAR = 12'd1970;
  localparam logic [6:0]         BASE_C100 = 7'd70;
  localparam logic [8:0]         BASE_C400 = 9'd370;
  localparam logic [6:0]         LAST_C100 = 7'd99;
  localparam logic [8:0]         LAST_C400 = 9'd399;
  localparam logic [8:0]         DAYS_PER_YEAR      = 9'd365;
  localparam logic [8:0]         DAYS_PER_LEAP_YEAR = 9'd366;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_Q,
    ST_DAY_R,
    ST_HOUR_Q,
    ST_HOUR_R,
    ST_MIN_Q,
    ST_MIN_R,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } esc_state_t;

  // Controller to datapath, one-cycle strobes but for year_step and month_step, which stay high while their walk runs
  typedef struct packed {
    logic take_in;
    logic day_q;
    logic day_r;
    logic hour_q;
    logic hour_r;
    logic min_q;
    logic min_r;
    logic year_step;
    logic month_step;
    logic out_load;
  } esc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic year_fit;
    logic month_fit;
    logic out_free;
  } esc_status_t;

  // Length of a month, February grows by one in a leap year
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
    logic [DAY_W-1:0] d;
    unique case (month)
      MONTH_FEB:               d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// File: design/esc_ifs.sv
// Valid/ready channel interfaces for the epoch seconds to calendar core.
// Depends on esc_pkg for field widths.
interface esc_in_if import esc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [EPOCH_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if import esc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   cal_year;
  logic [MONTH_W-1:0]  cal_month;
  logic [DAY_W-1:0]    cal_day;
  logic [HOUR_W-1:0]   cal_hour;
  logic [MINUTE_W-1:0] cal_minute;
  logic [SECOND_W-1:0] cal_second;

  modport source (output valid, output cal_year, output cal_month, output cal_day,
                  output cal_hour, output cal_minute, output cal_second, input ready);
  modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                  input cal_hour, input cal_minute, input cal_second, output ready);
endinterface

// File: design/esc_dp.sv
// Datapath: reciprocal-multiply time-of-day split, year and month walkers, output register.
// Depends on esc_pkg; driven by esc_ctrl through esc_cmd_t.
module esc_dp import esc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  esc_cmd_t            cmd,
  output esc_status_t         status,
  input  logic [EPOCH_W-1:0]  epoch_seconds,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [YEAR_W-1:0]   cal_year,
  output logic [MONTH_W-1:0]  cal_month,
  output logic [DAY_W-1:0]    cal_day,
  output logic [HOUR_W-1:0]   cal_hour,
  output logic [MINUTE_W-1:0] cal_minute,
  output logic [SECOND_W-1:0] cal_second
);

  logic [EPOCH_W-1:0]  tsec;
  logic [DAYS_W-1:0]   days;
  logic [SOD_W-1:0]    sod;
  logic [SOH_W-1:0]    soh;
  logic [YEAR_W-1:0]   year;
  logic [6:0]          c100;
  logic [8:0]          c400;
  logic [MONTH_W-1:0]  month;
  logic [HOUR_W-1:0]   hr;
  logic [MINUTE_W-1:0] mins;
  logic [SECOND_W-1:0] secs;

  logic [50:0]         day_prod;
  logic [31:0]         day_back;
  logic [31:0]         sod_full;
  logic [25:0]         hour_prod;
  logic [SOD_W-1:0]    hour_back;
  logic [SOD_W-1:0]    soh_full;
  logic [19:0]         min_prod;
  logic [SOH_W-1:0]    min_back;
  logic [SOH_W-1:0]    secs_full;
  logic                leap;
  logic [8:0]          ylen;
  logic [DAY_W-1:0]    mlen;

  // Quotients by reciprocal multiply, remainders by multiply back and subtract
  always_comb begin
    day_prod  = {26'b0, tsec[EPOCH_W-1:7]} * {25'b0, DAY_RECIP};
    day_back  = {16'b0, days} * {15'b0, SECS_PER_DAY};
    sod_full  = tsec - day_back;
    hour_prod = {13'b0, sod[SOD_W-1:4]} * {12'b0, HOUR_RECIP};
    hour_back = {12'b0, hr} * SECS_PER_HOUR;
    soh_full  = sod - hour_back;
    min_prod  = {10'b0, soh[SOH_W-1:2]} * {9'b0, MIN_RECIP};
    min_back  = {6'b0, mins} * SECS_PER_MIN;
    secs_full = soh - min_back;
  end

  // Leap rule from year mod 4 and the running mod 100 / mod 400 counters
  always_comb begin
    leap = (year[1:0] == 2'b00) && ((c100 != '0) || (c400 == '0));
    ylen = leap ? DAYS_PER_LEAP_YEAR : DAYS_PER_YEAR;
    mlen = month_days(month, leap);
  end

  assign status.year_fit  = (days >= {{(DAYS_W-9){1'b0}}, ylen});
  assign status.month_fit = (month != MONTH_DEC) &&
                            (days >= {{(DAYS_W-DAY_W){1'b0}}, mlen});
  assign status.out_free  = !out_valid || out_ready;

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      tsec  <= epoch_seconds;
      year  <= BASE_YEAR;
      c100  <= BASE_C100;
      c400  <= BASE_C400;
      month <= MONTH_JAN;
    end else if (cmd.day_q) begin
      days <= day_prod[50:35];
    end else if (cmd.day_r) begin
      sod <= sod_full[SOD_W-1:0];
    end else if (cmd.hour_q) begin
      hr <= hour_prod[25:21];
    end else if (cmd.hour_r) begin
      soh <= soh_full[SOH_W-1:0];
    end else if (cmd.min_q) begin
      mins <= min_prod[19:14];
    end else if (cmd.min_r) begin
      secs <= secs_full[SECOND_W-1:0];
    end else if (cmd.year_step) begin
      days <= days - {{(DAYS_W-9){1'b0}}, ylen};
      year <= year + 1'b1;
      c100 <= (c100 == LAST_C100) ? '0 : c100 + 1'b1;
      c400 <= (c400 == LAST_C400) ? '0 : c400 + 1'b1;
    end else if (cmd.month_step) begin
      days  <= days - {{(DAYS_W-DAY_W){1'b0}}, mlen};
      month <= month + 1'b1;
    end
  end

  // Output register, holds until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cal_year   <= year;
      cal_month  <= month;
      cal_day    <= days[DAY_W-1:0] + 1'b1;
      cal_hour   <= hr;
      cal_minute <= mins;
      cal_second <= secs;
    end
  end

endmodule

// File: design/esc_ctrl.sv
// Controller: sequences the time-of-day split, the year walk and the month walk.
// Depends on esc_pkg; commands esc_dp.
module esc_ctrl import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  esc_status_t status,
  output esc_cmd_t    cmd
);

  esc_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command strobes
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_DAY_Q;
        end
      end
      ST_DAY_Q: begin
        cmd.day_q  = 1'b1;
        state_next = ST_DAY_R;
      end
      ST_DAY_R: begin
        cmd.day_r  = 1'b1;
        state_next = ST_HOUR_Q;
      end
      ST_HOUR_Q: begin
        cmd.hour_q = 1'b1;
        state_next = ST_HOUR_R;
      end
      ST_HOUR_R: begin
        cmd.hour_r = 1'b1;
        state_next = ST_MIN_Q;
      end
      ST_MIN_Q: begin
        cmd.min_q  = 1'b1;
        state_next = ST_MIN_R;
      end
      ST_MIN_R: begin
        cmd.min_r  = 1'b1;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        if (status.year_fit) begin
          cmd.year_step = 1'b1;
        end else begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (status.month_fit) begin
          cmd.month_step = 1'b1;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Wait for the output register to free up
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/epoch_seconds_to_calendar_core.sv
// The input is taken in ST_IDLE; the time-of-day split, then the year walk (one year per cycle)
// and the month walk run before the result is loaded into the output register.
// A new item is taken only after the last one is loaded; the multipliers, year walker and
// month walker serve one item at a time. A finished result waits in the output register
// while the next item is taken. Synchronous active-high rst clears the controller and
// the output valid; no memories to clear.
module epoch_seconds_to_calendar_core import esc_pkg::*; (
  input logic       clk,
  input logic       rst,
  esc_in_if.sink    in_ch,
  esc_out_if.source out_ch
);

  esc_cmd_t    cmd;
  esc_status_t status;

  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  esc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (in_ch.epoch_seconds),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .cal_year      (out_ch.cal_year),
    .cal_month     (out_ch.cal_month),
    .cal_day       (out_ch.cal_day),
    .cal_hour      (out_ch.cal_hour),
    .cal_minute    (out_ch.cal_minute),
    .cal_second    (out_ch.cal_second)
  );

endmodule

// File: design/esc_checker.sv
// Port-level checker for the epoch seconds to calendar core, with its bind.
// Depends on esc_pkg and the assertion macros header.
`include "epoch_seconds_to_calendar_core_macros.svh"

module esc_checker import esc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [YEAR_W-1:0]   cal_year,
  input logic [MONTH_W-1:0]  cal_month,
  input logic [DAY_W-1:0]    cal_day,
  input logic [HOUR_W-1:0]   cal_hour,
  input logic [MINUTE_W-1:0] cal_minute,
  input logic [SECOND_W-1:0] cal_second
);

  logic [YEAR_W+MONTH_W+DAY_W+HOUR_W+MINUTE_W+SECOND_W-1:0] out_word;

  assign out_word = {cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second};

  // Busy after taking an item
  `ESC_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after transfer")

  // A new result only appears after a conversion ran
  `ESC_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(!in_ready), "result from idle")

  // Results lie inside the calendar
  `ESC_ASSERT_IMP(a_fields_legal, out_valid, (cal_month >= 4'd1) && (cal_month <= 4'd12) && (cal_day >= 5'd1) && (cal_hour <= 5'd23) && (cal_minute <= 6'd59) && (cal_second <= 6'd59) && (cal_year >= 12'd1970) && (cal_year <= 12'd2106), "field out of range")

  // Stalled result holds
  `ESC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cal_year   (out_ch.cal_year),
  .cal_month  (out_ch.cal_month),
  .cal_day    (out_ch.cal_day),
  .cal_hour   (out_ch.cal_hour),
  .cal_minute (out_ch.cal_minute),
  .cal_second (out_ch.cal_second)
);

// File: tb/sv/tb_epoch_seconds_to_calendar_core.sv
// Self-checking testbench for epoch_seconds_to_calendar_core: drives epoch second counts,
// predicts each Gregorian date and time of day, and compares every result transfer.
// Depends on esc_pkg and the esc_in_if / esc_out_if channel interfaces from the design.
module tb_epoch_seconds_to_calendar_core;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned RANDOM_ITEMS  = 1126;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned LONG_HOLD     = 500;
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } cal_date_t;

  // One queued input: the second count, and whether to wait for an empty pipe first
  typedef struct packed {
    logic               drain_first;
    logic [EPOCH_W-1:0] secs;
  } epoch_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  epoch_seconds_to_calendar_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  epoch_item_t stim_queue[$];
  cal_date_t   pending_dates[$];

  int unsigned cycles        = 0;
  int unsigned dates_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned orphan_dates  = 0;
  int unsigned send_gap      = 0;
  int unsigned send_calm     = 0;
  int unsigned recv_stall    = 0;
  int unsigned recv_calm     = 0;
  int unsigned hold_left     = 0;
  int unsigned year_lo       = 4095;
  int unsigned year_hi       = 0;

  always #(HALF_PERIOD) clk = ~clk;

  // Gregorian calendar helpers
  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_year(input int unsigned y);
    return is_leap(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Expected date: split off time of day, then walk years and months
  function automatic cal_date_t calendar_of(input logic [EPOCH_W-1:0] secs);
    cal_date_t   r;
    int unsigned t;
    int unsigned days;
    int unsigned yr;
    int unsigned mo;
    t        = secs;
    r.second = SECOND_W'(t % 60);
    r.minute = MINUTE_W'((t / 60) % 60);
    r.hour   = HOUR_W'((t / 3600) % 24);
    days     = t / 86400;
    yr       = 32'(BASE_YEAR);
    mo       = 1;
    while (days >= days_in_year(yr)) begin
      days -= days_in_year(yr);
      yr++;
    end
    while (mo < 12 && days >= month_length(yr, mo)) begin
      days -= month_length(yr, mo);
      mo++;
    end
    r.year  = YEAR_W'(yr);
    r.month = MONTH_W'(mo);
    r.day   = DAY_W'(days + 1);
    return r;
  endfunction

  // Second count of a date and time, nudged by a few seconds and clamped to 32 bits
  function automatic logic [EPOCH_W-1:0] epoch_of(input int unsigned y, input int unsigned m,
                                                  input int unsigned d, input int unsigned h,
                                                  input int unsigned mi, input int unsigned s,
                                                  input int nudge);
    longint days;
    longint total;
    days = d - 1;
    for (int unsigned k = BASE_YEAR; k < y; k++) days += days_in_year(k);
    for (int unsigned k = 1; k < m; k++) days += month_length(y, k);
    total = days * 86400 + h * 3600 + mi * 60 + s + nudge;
    if (total < 0) total = 0;
    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    return total[EPOCH_W-1:0];
  endfunction

  // Idle length: mostly short, a few long, and now and then a calm stretch with none
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if (roll < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_item(input logic [EPOCH_W-1:0] secs, input logic drain_first);
    stim_queue.push_back({drain_first, secs});
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Drive input transfers from the stimulus queue, with random gaps between items
  always @(posedge clk) begin : drive_epochs
    logic        offer;
    epoch_item_t nxt;
    if (rst) begin
      in_ch.valid         <= 1'b0;
      in_ch.epoch_seconds <= '0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        pending_dates.push_back(calendar_of(in_ch.epoch_seconds));
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (stim_queue.size() != 0 &&
                     !(stim_queue[0].drain_first && pending_dates.size() != 0)) begin
          nxt = stim_queue.pop_front();
          in_ch.epoch_seconds <= nxt.secs;
          offer = 1'b1;
          send_gap = idle_len(send_calm);
        end
      end
      in_ch.valid <= offer;
    end
  end

  // Check result transfers against the oldest prediction; stall the output at random
  always @(posedge clk) begin : check_dates
    cal_date_t want;
    logic      take;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        dates_checked++;
        if (pending_dates.size() == 0) begin
          orphan_dates++;
          $error("result transfer with no conversion outstanding");
        end else begin
          want = pending_dates.pop_front();
          check_field("cal_year",   want.year,   out_ch.cal_year);
          check_field("cal_month",  want.month,  out_ch.cal_month);
          check_field("cal_day",    want.day,    out_ch.cal_day);
          check_field("cal_hour",   want.hour,   out_ch.cal_hour);
          check_field("cal_minute", want.minute, out_ch.cal_minute);
          check_field("cal_second", want.second, out_ch.cal_second);
          if (want.year < year_lo) year_lo = want.year;
          if (want.year > year_hi) year_hi = want.year;
        end
        // hold off once for long enough that the block backs up into its input
        if (dates_checked == HOLD_AT) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        take = 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        take = 1'b0;
      end else begin
        take = 1'b1;
        if ($urandom_range(0, 3) == 0) recv_stall = idle_len(recv_calm);
      end
      out_ch.ready <= take;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned y;
    int unsigned m;
    int          nudge;
    logic        drain;
    logic [EPOCH_W-1:0] secs;

    // Corners: time-of-day rollovers, leap rules, signed and unsigned range ends
    queue_item(32'd0, 1'b0);
    queue_item(32'd59, 1'b0);
    queue_item(32'd60, 1'b0);
    queue_item(32'd3599, 1'b0);
    queue_item(32'd3600, 1'b0);
    queue_item(32'd86399, 1'b0);
    queue_item(32'd86400, 1'b0);
    queue_item(epoch_of(1970, 12, 31, 23, 59, 59, 0), 1'b0);
    queue_item(epoch_of(1971, 1, 1, 0, 0, 0, 0), 1'b0);
    queue_item(epoch_of(1972, 2, 29, 12, 0, 0, 0), 1'b0);
    queue_item(epoch_of(1972, 3, 1, 0, 0, 0, 0), 1'b0);
    queue_item(epoch_of(1972, 12, 31, 23, 59, 59, 0), 1'b0);
    queue_item(epoch_of(2000, 2, 29, 0, 0, 0, 0), 1'b0);
    queue_item(epoch_of(2000, 12, 31, 23, 59, 59, 0), 1'b0);
    queue_item(epoch_of(2100, 2, 28, 23, 59, 59, 0), 1'b0);
    queue_item(epoch_of(2100, 3, 1, 0, 0, 0, 0), 1'b0);
    queue_item(epoch_of(2105, 12, 31, 23, 59, 59, 0), 1'b0);
    queue_item(epoch_of(2106, 1, 1, 0, 0, 0, 0), 1'b0);
    queue_item(32'h7FFF_FFFF, 1'b0);
    queue_item(32'h8000_0000, 1'b0);
    queue_item(32'hAAAA_AAAA, 1'b0);
    queue_item(32'h5555_5555, 1'b0);
    queue_item(32'hFFFF_FFFE, 1'b0);
    queue_item(32'hFFFF_FFFF, 1'b0);

    // Random mix weighted toward year, month and day boundaries
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      kind  = $urandom_range(0, 99);
      nudge = int'($urandom_range(0, 8)) - 4;
      drain = (i == 0) || (i == 700) || (i > 400 && $urandom_range(0, 99) == 0);
      if (kind < 35) begin
        secs = $urandom;
      end else if (kind < 60) begin
        y    = $urandom_range(1971, 2106);
        secs = epoch_of(y, 1, 1, 0, 0, 0, nudge);
      end else if (kind < 85) begin
        y    = $urandom_range(1970, 2105);
        m    = $urandom_range(2, 12);
        secs = epoch_of(y, m, 1, 0, 0, 0, nudge);
      end else if (kind < 95) begin
        y    = $urandom_range(1970, 2105);
        m    = $urandom_range(1, 12);
        secs = epoch_of(y, m, $urandom_range(1, month_length(y, m)),
                        $urandom_range(0, 1) ? 23 : 0, $urandom_range(0, 1) ? 59 : 0,
                        $urandom_range(0, 1) ? 59 : 0, 0);
      end else begin
        secs = 32'hFFFF_FFFF - $urandom_range(0, 40_000_000);
      end
      queue_item(secs, drain);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Let every item go in, every result come out, then allow for stray outputs
    while (stim_queue.size() != 0 || in_ch.valid) @(negedge clk);
    while (pending_dates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d epoch counts, years %0d..%0d, with leap corners, range ends,",
             dates_checked, year_lo, year_hi);
    $display("a long output hold-off and input pauses until the pipe drained.");
    if (mismatches == 0 && orphan_dates == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/esc_pkg.sv
design/esc_ifs.sv
design/esc_dp.sv
design/esc_ctrl.sv
design/epoch_seconds_to_calendar_core.sv
design/esc_checker.sv
tb/sv/tb_epoch_seconds_to_calendar_core.sv
